FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is disabled while reset is high
`define PRA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("priority arbiter check failed");

// Clocked property that also holds during reset
`define PRA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("priority arbiter check failed");

`endif

FILE: hw/rtl/pra_pkg.sv
// Shared types and codes of the priority resource arbiter
package pra_pkg;

  localparam logic [1:0] OP_REQUEST  = 2'd0;
  localparam logic [1:0] OP_RELEASE  = 2'd1;
  localparam logic [1:0] OP_REL_USE  = 2'd2;
  localparam logic [1:0] OP_PRIORITY = 2'd3;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_LIMIT  = 2'd1;
  localparam logic [1:0] ERR_FULL   = 2'd2;

  localparam int CID_W = 16;
  localparam int PRI_W = 8;
  localparam int ORD_W = 32;
  localparam int ENT_W = CID_W + PRI_W + ORD_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_HSCAN,
    ST_FIN
  } state_t;

endpackage

FILE: hw/rtl/priority_resource_arbiter.sv
// Priority resource arbiter: counting semaphore with a priority wait queue
//
// Input channel (in_valid / in_stall) carries one operation item: request,
// release, use-only release or priority change. Output channel (out_valid /
// out_stall) returns exactly one result item per operation. The capacity
// register is written over cfg_valid / cfg_ready; the user must write it
// only while the block is idle, which the block itself does not enforce;
// values above USER_SLOTS saturate. Each item runs a scan over N =
// max(USER_SLOTS, QUEUE_DEPTH) table entries through one compare unit and
// the registered RAM read ports, an action state, a second scan to find the
// new queue head and a final state that loads the result into the output
// register. A priority change for a client with k queued entries repeats
// the first scan and the action state k extra times, where k is at most
// MAX_PER_CLIENT. in_stall is high from acceptance until the result is
// loaded into the output register; the next item is taken while that
// result still waits. A stalled result holds the block in its final state
// until the output register is free. Reset clears all valid bits, the
// counters and the order counter and sets capacity to 1.
module priority_resource_arbiter
  import pra_pkg::*;
#(
  parameter int USER_SLOTS     = 64,
  parameter int QUEUE_DEPTH    = 64,
  parameter int MAX_PER_CLIENT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] client_id,
  input  logic [7:0]  priority_req,
  input  logic [31:0] timestamp,
  input  logic        release_all,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        granted,
  output logic        released_in_use,
  output logic        removed_from_queue,
  output logic [1:0]  error_code,
  output logic [6:0]  free_units,
  output logic [6:0]  queue_length,
  output logic [15:0] head_client,
  output logic        head_valid
);

  localparam int N   = (USER_SLOTS > QUEUE_DEPTH) ? USER_SLOTS : QUEUE_DEPTH;
  localparam int CW  = $clog2(N + 1);
  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int UAW = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int UCW = $clog2(USER_SLOTS + 1);
  localparam int FW  = (UCW > 7) ? UCW : 7;

  state_t state, state_next;

  logic [6:0]       cap;
  logic [ORD_W-1:0] order_counter;
  logic [UCW-1:0]   used;
  logic [QCW-1:0]   qcnt;
  logic             user_valid [USER_SLOTS];
  logic             entry_valid [QUEUE_DEPTH];
  logic             done [QUEUE_DEPTH];

  logic [1:0]       op;
  logic [CID_W-1:0] cid;
  logic [PRI_W-1:0] pri;
  logic             all;

  logic [CW-1:0]    cnt;
  logic [CW-1:0]    pj;
  logic             scanning, e_ok, u_ok;
  logic [QAW-1:0]   qj;
  logic [UAW-1:0]   uj;

  logic [ENT_W-1:0] e_rd, e_wdata;
  logic [CID_W-1:0] u_rd;
  logic [CID_W-1:0] e_cli;
  logic [PRI_W-1:0] e_pri;
  logic [ORD_W-1:0] e_ord;
  logic             e_we, u_we;
  logic [QAW-1:0]   e_waddr;

  logic             hd_found, fq_found, old_found, pm_found, fu_found, rel;
  logic [QAW-1:0]   hd_idx, fq_idx, old_idx, pm_idx;
  logic [PRI_W-1:0] hd_pri;
  logic [ORD_W-1:0] hd_ord, old_ord, pm_ord;
  logic [CID_W-1:0] hd_cli;
  logic [QCW-1:0]   mine;
  logic [UAW-1:0]   fu_idx;

  logic             r_granted, r_removed;
  logic [1:0]       r_err;
  logic             grant_ok, scan_end;
  logic [FW-1:0]    cap_w, used_w;

  assign cfg_ready = 1'b1;

  assign pj    = cnt - CW'(1);
  assign qj    = pj[QAW-1:0];
  assign uj    = pj[UAW-1:0];
  assign e_ok  = scanning && (cnt != '0) && (pj < CW'(QUEUE_DEPTH));
  assign u_ok  = scanning && (cnt != '0) && (pj < CW'(USER_SLOTS));
  assign scan_end = (cnt == CW'(N));
  assign {e_cli, e_pri, e_ord} = e_rd;

  assign grant_ok = (FW'(used) < FW'(cap)) && (!hd_found || hd_cli == cid);
  assign cap_w  = FW'(cap);
  assign used_w = FW'(used);

  pra_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (cnt[QAW-1:0]),
    .rdata (e_rd)
  );

  pra_ram #(.WIDTH(CID_W), .DEPTH(USER_SLOTS)) u_user_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (fu_idx),
    .wdata (cid),
    .raddr (cnt[UAW-1:0]),
    .rdata (u_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SCAN;
      ST_SCAN:  if (scan_end) state_next = ST_ACT;
      ST_ACT: begin
        if (op == OP_PRIORITY && pm_found) state_next = ST_SCAN;
        else state_next = ST_HSCAN;
      end
      ST_HSCAN: if (scan_end) state_next = ST_FIN;
      ST_FIN:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = (state != ST_IDLE);
    scanning = (state == ST_SCAN) || (state == ST_HSCAN);
    e_we     = 1'b0;
    u_we     = 1'b0;
    e_waddr  = fq_idx;
    e_wdata  = {cid, pri, order_counter};
    if (state == ST_ACT) begin
      case (op)
        OP_REQUEST: begin
          u_we = grant_ok;
          e_we = !grant_ok && (32'(mine) < 32'(MAX_PER_CLIENT)) && fq_found;
        end
        OP_PRIORITY: begin
          e_we    = pm_found;
          e_waddr = pm_idx;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cap           <= 7'd1;
      order_counter <= '0;
      used          <= '0;
      qcnt          <= '0;
      out_valid     <= 1'b0;
      cnt           <= '0;
      for (int i = 0; i < USER_SLOTS; i++) user_valid[i] <= 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) entry_valid[i] <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        cap <= ({25'd0, cfg_data} > 32'(USER_SLOTS)) ? 7'(USER_SLOTS) : cfg_data;
      end
      if (out_valid && !out_stall && state != ST_FIN) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op        <= operation;
            cid       <= client_id;
            pri       <= priority_req;
            all       <= release_all;
            rel       <= 1'b0;
            r_granted <= 1'b0;
            r_removed <= 1'b0;
            r_err     <= ERR_NONE;
            cnt       <= '0;
            for (int i = 0; i < QUEUE_DEPTH; i++) done[i] <= 1'b0;
          end
        end

        ST_SCAN, ST_HSCAN: begin
          cnt <= scan_end ? '0 : cnt + CW'(1);
          if (cnt == '0) begin
            hd_found  <= 1'b0;
            fq_found  <= 1'b0;
            old_found <= 1'b0;
            pm_found  <= 1'b0;
            fu_found  <= 1'b0;
            mine      <= '0;
          end
          if (e_ok) begin
            if (entry_valid[qj]) begin
              if (!hd_found || e_pri > hd_pri || (e_pri == hd_pri && e_ord < hd_ord)) begin
                hd_found <= 1'b1;
                hd_idx   <= qj;
                hd_pri   <= e_pri;
                hd_ord   <= e_ord;
                hd_cli   <= e_cli;
              end
              if (e_cli == cid) begin
                mine <= mine + QCW'(1);
                if (!old_found || e_ord < old_ord) begin
                  old_found <= 1'b1;
                  old_idx   <= qj;
                  old_ord   <= e_ord;
                end
                if (!done[qj] && (!pm_found || e_ord < pm_ord)) begin
                  pm_found <= 1'b1;
                  pm_idx   <= qj;
                  pm_ord   <= e_ord;
                end
              end
            end else if (!fq_found) begin
              fq_found <= 1'b1;
              fq_idx   <= qj;
            end
          end
          if (u_ok) begin
            if (user_valid[uj]) begin
              // free matching units on the first pass of a release
              if (state == ST_SCAN && (op == OP_RELEASE || op == OP_REL_USE) &&
                  u_rd == cid && (all || !rel)) begin
                user_valid[uj] <= 1'b0;
                rel            <= 1'b1;
                used           <= used - UCW'(1);
              end
            end else if (!fu_found) begin
              fu_found <= 1'b1;
              fu_idx   <= uj;
            end
          end
        end

        ST_ACT: begin
          case (op)
            OP_REQUEST: begin
              if (grant_ok) begin
                r_granted <= 1'b1;
                if (hd_found) begin
                  entry_valid[hd_idx] <= 1'b0;
                  qcnt                <= qcnt - QCW'(1);
                end
                user_valid[fu_idx] <= 1'b1;
                used               <= used + UCW'(1);
              end else if (32'(mine) >= 32'(MAX_PER_CLIENT)) begin
                r_err <= ERR_LIMIT;
              end else if (!fq_found) begin
                r_err <= ERR_FULL;
              end else begin
                entry_valid[fq_idx] <= 1'b1;
                qcnt                <= qcnt + QCW'(1);
                order_counter       <= order_counter + ORD_W'(1);
              end
            end
            OP_RELEASE: begin
              if (!rel && old_found) begin
                entry_valid[old_idx] <= 1'b0;
                qcnt                 <= qcnt - QCW'(1);
                r_removed            <= 1'b1;
              end
            end
            OP_PRIORITY: begin
              // renumber the oldest not yet renumbered entry as newest
              if (pm_found) begin
                done[pm_idx]  <= 1'b1;
                order_counter <= order_counter + ORD_W'(1);
              end
            end
            default: ;
          endcase
        end

        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            granted            <= r_granted;
            released_in_use    <= rel;
            removed_from_queue <= r_removed;
            error_code         <= r_err;
            free_units         <= (cap_w > used_w) ? 7'(cap_w - used_w) : 7'd0;
            queue_length       <= qcnt[6:0] & 7'h7F;
            head_valid         <= hd_found;
            head_client        <= hd_found ? hd_cli : '0;
          end
        end

        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pra_ram.sv
// Generic single write port RAM with registered read
module pra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/pra_checker.sv
// Port-level checker for the priority resource arbiter and its bind
`include "assert_macros.svh"

module pra_checker
  import pra_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        granted,
  input logic        released_in_use,
  input logic        removed_from_queue,
  input logic [1:0]  error_code,
  input logic [15:0] head_client,
  input logic        head_valid
);

  `PRA_ASSERT(a_busy_after_accept, clk, rst, (in_valid && !in_stall) |=> in_stall)
  `PRA_ASSERT(a_head_zero, clk, rst, (out_valid && !head_valid) |-> (head_client == 16'd0))
  `PRA_ASSERT(a_grant_clean, clk, rst,
    (out_valid && granted) |-> (error_code == ERR_NONE && !released_in_use && !removed_from_queue))
  `PRA_ASSERT(a_removed_only_alone, clk, rst,
    (out_valid && removed_from_queue) |-> !released_in_use)
  `PRA_ASSERT_ALWAYS(a_idle_after_reset, clk, (!rst && $past(rst)) |-> !out_valid)

endmodule

bind priority_resource_arbiter pra_checker u_pra_checker (.*);
